@@ hdl/temporal_history_trust_defines.svh @@
// assertion macros for the temporal history trust block
// needs clk and arst_n in the scope of use
`ifndef TEMPORAL_HISTORY_TRUST_DEFINES_SVH
`define TEMPORAL_HISTORY_TRUST_DEFINES_SVH

// condition implies consequence in the same cycle
`define THT_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define THT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tht_pkg.sv @@
// shared constants, types and helpers of the temporal history trust block
// no dependencies
package tht_pkg;

	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam int THR_W = 15;
	localparam int DIV_STEPS = 3;
	localparam int DIV_STAGES = THR_W / DIV_STEPS;
	localparam int CFG_IDX_W = 4;
	localparam int OCCL_PEN = 32768;
	localparam logic [15:0] DIS_TERM = (OCCL_PEN >= 32768) ? 16'd0
		: 16'(32768 - OCCL_PEN);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_THR  = 4'd0,
		REG_MOTION_THR = 4'd1,
		REG_COLOR_THR  = 4'd2,
		REG_REACT_PEN  = 4'd3,
		REG_DECAY_RATE = 4'd4,
		REG_REC_FLOOR  = 4'd5,
		REG_MIN_WEIGHT = 4'd6,
		REG_MAX_WEIGHT = 4'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TERM_DIV  = 2'd0,
		TERM_FULL = 2'd1,
		TERM_ZERO = 2'd2
	} term_sel_t;

	typedef struct packed {
		logic        clear;
		logic        dis;
		logic [15:0] react;
		logic [15:0] memory;
		term_sel_t   dsel;
		term_sel_t   msel;
		term_sel_t   csel;
	} side_t;

	function automatic logic [15:0] sat_one(input logic [31:0] v);
		return (v > 32'(ONE_Q15)) ? ONE_Q15 : v[15:0];
	endfunction

	// mag is the non-negative delta, thr the threshold
	function automatic term_sel_t term_sel(input logic [15:0] mag, input logic [THR_W-1:0] thr);
		term_sel_t s;
		if (thr == '0)
			s = TERM_ZERO;
		else if (mag == '0)
			s = TERM_FULL;
		else if (mag >= {1'b0, thr})
			s = TERM_ZERO;
		else
			s = TERM_DIV;
		return s;
	endfunction

	function automatic logic [15:0] term_val(input term_sel_t s, input logic [THR_W-1:0] q);
		logic [15:0] r;
		case (s)
			TERM_FULL: r = ONE_Q15;
			TERM_ZERO: r = '0;
			default:   r = ONE_Q15 - {1'b0, q};
		endcase
		return r;
	endfunction

endpackage

@@ hdl/tht_ifs.sv @@
// handshake channel interfaces of the temporal history trust block
// depends on tht_pkg
interface tht_pix_in_if;
	logic               valid;
	logic               ready;
	logic               clear_history;
	logic signed [15:0] depth_delta;
	logic signed [15:0] motion_length;
	logic signed [15:0] luma_delta;
	logic [15:0]        reactive_amount;
	logic               is_disoccluded;
	logic [15:0]        prior_trust;
	modport source(output valid, clear_history, depth_delta, motion_length, luma_delta,
		reactive_amount, is_disoccluded, prior_trust, input ready);
	modport sink(input valid, clear_history, depth_delta, motion_length, luma_delta,
		reactive_amount, is_disoccluded, prior_trust, output ready);
endinterface

interface tht_pix_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] combined_trust;
	logic [15:0] history_weight;
	logic [15:0] rejection;
	logic [15:0] evidence_trust;
	modport source(output valid, combined_trust, history_weight, rejection, evidence_trust,
		input ready);
	modport sink(input valid, combined_trust, history_weight, rejection, evidence_trust,
		output ready);
endinterface

interface tht_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tht_pkg::CFG_IDX_W-1:0]  index;
	logic [15:0]                    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/tht_div.sv @@
// pipelined restoring divider, (num << 15) / den for num < den
// depends on tht_pkg
module tht_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tht_pkg::THR_W-1:0]   num,
	input  logic [tht_pkg::THR_W-1:0]   den,
	output logic [tht_pkg::THR_W-1:0]   quo
);
	logic [tht_pkg::THR_W-1:0] rem_s [tht_pkg::DIV_STAGES];
	logic [tht_pkg::THR_W-1:0] quo_s [tht_pkg::DIV_STAGES];

	for (genvar k = 0; k < tht_pkg::DIV_STAGES; k++) begin : g_stage
		logic [tht_pkg::THR_W-1:0] rem_c;
		logic [tht_pkg::THR_W-1:0] quo_c;

		always_comb begin
			logic [tht_pkg::THR_W:0]   sh;
			logic [tht_pkg::THR_W-1:0] r;
			logic [tht_pkg::THR_W-1:0] q;
			if (k == 0) begin
				r = num;
				q = '0;
			end else begin
				r = rem_s[(k > 0) ? k-1 : 0];
				q = quo_s[(k > 0) ? k-1 : 0];
			end
			// DIV_STEPS (three) quotient bits per stage
			for (int j = 0; j < tht_pkg::DIV_STEPS; j++) begin
				sh = {r, 1'b0};
				if (sh >= {1'b0, den}) begin
					sh = sh - {1'b0, den};
					q = {q[tht_pkg::THR_W-2:0], 1'b1};
				end else begin
					q = {q[tht_pkg::THR_W-2:0], 1'b0};
				end
				r = sh[tht_pkg::THR_W-1:0];
			end
			rem_c = r;
			quo_c = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_c;
				quo_s[k] <= quo_c;
			end
		end
	end

	assign quo = quo_s[tht_pkg::DIV_STAGES-1];
endmodule

@@ hdl/temporal_history_trust.sv @@
// throughput: one word per cycle; the whole pipeline advances together and holds on a stall
// stages: input/products, five divider stages (3 quotient bits each), seven multiply/clamp
// reset: arst_n clears the valid bits and loads the register defaults; data is not reset
// cfg port is always ready and must only be written while the pipeline is empty
`include "temporal_history_trust_defines.svh"

module temporal_history_trust (
	input  logic        clk,
	input  logic        arst_n,
	tht_pix_in_if.sink  pix_in,
	tht_pix_out_if.source pix_out,
	tht_cfg_if.sink     cfg
);
	localparam int ND = tht_pkg::DIV_STAGES;

	// configuration registers
	logic [14:0] depth_thr_q, motion_thr_q, color_thr_q;
	logic [15:0] react_pen_q, decay_rate_q, rec_floor_q, min_weight_q, max_weight_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_thr_q  <= 15'd410;
			motion_thr_q <= 15'd2048;
			color_thr_q  <= 15'd3277;
			react_pen_q  <= 16'd4096;
			decay_rate_q <= 16'd3277;
			rec_floor_q  <= 16'd8192;
			min_weight_q <= 16'd1638;
			max_weight_q <= 16'd31130;
		end else if (cfg.valid) begin
			case (cfg.index)
				tht_pkg::REG_DEPTH_THR:  depth_thr_q  <= cfg.data[14:0];
				tht_pkg::REG_MOTION_THR: motion_thr_q <= cfg.data[14:0];
				tht_pkg::REG_COLOR_THR:  color_thr_q  <= cfg.data[14:0];
				tht_pkg::REG_REACT_PEN:  react_pen_q  <= cfg.data;
				tht_pkg::REG_DECAY_RATE: decay_rate_q <= cfg.data;
				tht_pkg::REG_REC_FLOOR:  rec_floor_q  <= cfg.data;
				tht_pkg::REG_MIN_WEIGHT: min_weight_q <= cfg.data;
				tht_pkg::REG_MAX_WEIGHT: max_weight_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// whole pipe moves unless the output word is stuck
	logic adv;
	logic v_m7;
	assign adv = !v_m7 || pix_out.ready;
	assign pix_in.ready = adv;

	// ---------------- stage 1: magnitudes, term selection, reactive and memory
	logic [15:0] dmag_c, mmag_c, cmag_c, rt_c, factor_c, dec_c, floor_c;
	logic [31:0] p_c;
	tht_pkg::side_t side_c;

	always_comb begin
		// depth is signed: anything not positive gives full trust unless the threshold is zero
		dmag_c = pix_in.depth_delta[15] ? 16'd0 : pix_in.depth_delta;
		mmag_c = pix_in.motion_length[15] ? 16'(-pix_in.motion_length) : pix_in.motion_length;
		cmag_c = pix_in.luma_delta[15] ? 16'(-pix_in.luma_delta) : pix_in.luma_delta;
		p_c = (32'(pix_in.reactive_amount) * 32'(react_pen_q)) >> 12;
		rt_c = (p_c >= 32'(tht_pkg::ONE_Q15)) ? 16'd0 : 16'(32'(tht_pkg::ONE_Q15) - p_c);
		factor_c = (decay_rate_q >= tht_pkg::ONE_Q15) ? 16'd0 : tht_pkg::ONE_Q15 - decay_rate_q;
		dec_c = tht_pkg::sat_one((32'(pix_in.prior_trust) * 32'(factor_c)) >> 15);
		floor_c = tht_pkg::sat_one(32'(rec_floor_q));
		side_c.clear = pix_in.clear_history;
		side_c.dis = pix_in.is_disoccluded;
		side_c.react = rt_c;
		side_c.memory = (dec_c > floor_c) ? dec_c : floor_c;
		side_c.dsel = tht_pkg::term_sel(dmag_c, depth_thr_q);
		side_c.msel = tht_pkg::term_sel(mmag_c, motion_thr_q);
		side_c.csel = tht_pkg::term_sel(cmag_c, color_thr_q);
	end

	logic           v_s1;
	tht_pkg::side_t side_s1;
	logic [14:0]    dnum_s1, mnum_s1, cnum_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_c;
			dnum_s1 <= dmag_c[14:0];
			mnum_s1 <= mmag_c[14:0];
			cnum_s1 <= cmag_c[14:0];
		end
	end

	// ---------------- divider stages, one per consistency term
	logic [14:0] dq, mq, cq;

	tht_div u_div_depth (.clk(clk), .en(adv), .num(dnum_s1), .den(depth_thr_q), .quo(dq));
	tht_div u_div_motion (.clk(clk), .en(adv), .num(mnum_s1), .den(motion_thr_q), .quo(mq));
	tht_div u_div_color (.clk(clk), .en(adv), .num(cnum_s1), .den(color_thr_q), .quo(cq));

	// side data rides alongside the divider
	logic           v_d [ND];
	tht_pkg::side_t side_d [ND];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s1;
			for (int k = 1; k < ND; k++)
				side_d[k] <= side_d[k-1];
		end
	end

	// ---------------- multiply chain
	logic [31:0] m1_c, m2_c, m3_c, ev_c, comb_c, w_c;
	logic [15:0] m1_m1, ct_m1, m2_m2, m3_m3, ev_m4, ev_m5, comb_m5, ev_m6, comb_m6, w_m6;
	tht_pkg::side_t side_m1, side_m2, side_m3, side_m4, side_m5, side_m6;
	logic v_m1, v_m2, v_m3, v_m4, v_m5, v_m6;

	assign m1_c = 32'(tht_pkg::term_val(side_d[ND-1].dsel, dq))
		* 32'(tht_pkg::term_val(side_d[ND-1].msel, mq));
	assign m2_c = 32'(m1_m1) * 32'(ct_m1);
	assign m3_c = 32'(m2_m2) * 32'(side_m2.react);
	// disocclusion term is either one or the constant penalty term
	assign ev_c = side_m3.dis ? ((32'(m3_m3) * 32'(tht_pkg::DIS_TERM)) >> 15) : 32'(m3_m3);
	assign comb_c = 32'(ev_m4) * 32'(side_m4.memory);
	assign w_c = 32'(comb_m5) * 32'(tht_pkg::sat_one(32'(max_weight_q)));

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_m1   <= m1_c[30:15];
			ct_m1   <= tht_pkg::term_val(side_d[ND-1].csel, cq);
			side_m1 <= side_d[ND-1];
			m2_m2   <= m2_c[30:15];
			side_m2 <= side_m1;
			m3_m3   <= m3_c[30:15];
			side_m3 <= side_m2;
			ev_m4   <= ev_c[15:0];
			side_m4 <= side_m3;
			ev_m5   <= ev_m4;
			comb_m5 <= comb_c[30:15];
			side_m5 <= side_m4;
			ev_m6   <= ev_m5;
			comb_m6 <= comb_m5;
			w_m6    <= w_c[30:15];
			side_m6 <= side_m5;
		end
	end

	// ---------------- output stage: weight clamp, zero on clear
	logic [15:0] wmin_c, wmax_c, wcl_c;
	logic [15:0] comb_m7, w_m7, rej_m7, ev_m7;

	always_comb begin
		wmin_c = tht_pkg::sat_one(32'(min_weight_q));
		wmax_c = tht_pkg::sat_one(32'(max_weight_q));
		wcl_c = (w_m6 < wmin_c) ? wmin_c : w_m6;
		// max wins when the clamps cross
		if (wcl_c > wmax_c)
			wcl_c = wmax_c;
		if (comb_m6 == '0)
			wcl_c = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_m6.clear) begin
				comb_m7 <= '0;
				w_m7    <= '0;
				rej_m7  <= '0;
				ev_m7   <= '0;
			end else begin
				comb_m7 <= comb_m6;
				w_m7    <= wcl_c;
				rej_m7  <= tht_pkg::ONE_Q15 - comb_m6;
				ev_m7   <= ev_m6;
			end
		end
	end

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < ND; k++)
				v_d[k] <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
			v_m5 <= 1'b0;
			v_m6 <= 1'b0;
			v_m7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_in.valid;
			v_d[0] <= v_s1;
			for (int k = 1; k < ND; k++)
				v_d[k] <= v_d[k-1];
			v_m1 <= v_d[ND-1];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
			v_m5 <= v_m4;
			v_m6 <= v_m5;
			v_m7 <= v_m6;
		end
	end

	assign pix_out.valid          = v_m7;
	assign pix_out.combined_trust = comb_m7;
	assign pix_out.history_weight = w_m7;
	assign pix_out.rejection      = rej_m7;
	assign pix_out.evidence_trust = ev_m7;

	// ---------------- checks
	`THT_ASSERT_NOW(a_rej_sum, pix_out.valid, ((17'(comb_m7) + 17'(rej_m7)) == 17'(tht_pkg::ONE_Q15)) || ((comb_m7 == '0) && (rej_m7 == '0) && (ev_m7 == '0)), "rejection does not complement combined trust")
	`THT_ASSERT_NOW(a_zero_weight, pix_out.valid && (comb_m7 == '0), w_m7 == '0, "weight nonzero with zero trust")
	`THT_ASSERT_NOW(a_comb_le_ev, pix_out.valid, comb_m7 <= ev_m7, "combined trust exceeds evidence")
	`THT_ASSERT_NEXT(a_stall_hold, v_m7 && !pix_out.ready, v_m7 && $stable(comb_m7) && $stable(w_m7) && $stable(v_m6), "pipeline moved during stall")
endmodule

@@ tb/sv/tht_trust_checker.sv @@
// scoreboard for the temporal history trust block: watches the cfg, pixel-in and pixel-out channels
// depends on tht_pkg and the channel interfaces in tht_ifs
module tht_trust_checker (
	input  logic          clk,
	input  logic          arst_n,
	tht_pix_in_if         pix_in,
	tht_pix_out_if        pix_out,
	tht_cfg_if            cfg,
	output int unsigned   fail_count,
	output int unsigned   pending,
	output int unsigned   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNITY = 32768;

	typedef struct {
		bit [15:0] combined;
		bit [15:0] weight;
		bit [15:0] rejection;
		bit [15:0] evidence;
	} trust_word_t;

	trust_word_t trust_q[$];

	// shadow copy of the register file
	bit [14:0] depth_thr, motion_thr, color_thr;
	bit [15:0] react_pen, decay, rec_floor, w_min, w_max;

	function automatic longint q15_clip(longint v);
		return (v > UNITY) ? UNITY : v;
	endfunction

	// saturate(1 - d/t), zero threshold disables
	function automatic longint consistency_term(longint d, longint t);
		if (t == 0) return 0;
		if (d <= 0) return UNITY;
		if (d >= t) return 0;
		return UNITY - ((d * UNITY) / t);
	endfunction

	function automatic longint abs_val(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic trust_word_t predict_trust(bit clr, logic signed [15:0] dd,
			logic signed [15:0] ml, logic signed [15:0] ld, bit [15:0] ra, bit dis,
			bit [15:0] prior);
		trust_word_t r;
		longint dt, mt, ct, rt, ot, p, ev, factor, decayed, mem, comb, wl, wh, w;
		r = '{default: 0};
		if (clr) return r;
		dt = consistency_term(longint'(dd), depth_thr);
		mt = consistency_term(abs_val(longint'(ml)), motion_thr);
		ct = consistency_term(abs_val(longint'(ld)), color_thr);
		p = (longint'(ra) * longint'(react_pen)) >>> 12;
		rt = (p >= UNITY) ? 0 : UNITY - p;
		if (dis)
			ot = (tht_pkg::OCCL_PEN >= UNITY) ? 0 : UNITY - tht_pkg::OCCL_PEN;
		else
			ot = UNITY;
		ev = (((((dt * mt) >>> 15) * ct >>> 15) * rt >>> 15) * ot) >>> 15;
		factor = (decay >= UNITY) ? 0 : UNITY - decay;
		decayed = q15_clip((longint'(prior) * factor) >>> 15);
		mem = (decayed > q15_clip(rec_floor)) ? decayed : q15_clip(rec_floor);
		comb = (ev * mem) >>> 15;
		if (comb == 0) begin
			w = 0;
		end else begin
			wl = q15_clip(w_min);
			wh = q15_clip(w_max);
			w = (comb * wh) >>> 15;
			if (w < wl) w = wl;
			if (w > wh) w = wh;
		end
		r.combined = comb[15:0];
		r.weight = w[15:0];
		r.rejection = 16'(UNITY - comb);
		r.evidence = ev[15:0];
		return r;
	endfunction

	assign pending = trust_q.size();

	always @(posedge clk or negedge arst_n) begin
		trust_word_t e;
		if (!arst_n) begin
			depth_thr = 15'd410;
			motion_thr = 15'd2048;
			color_thr = 15'd3277;
			react_pen = 16'd4096;
			decay = 16'd3277;
			rec_floor = 16'd8192;
			w_min = 16'd1638;
			w_max = 16'd31130;
			trust_q.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					tht_pkg::REG_DEPTH_THR:  depth_thr = cfg.data[14:0];
					tht_pkg::REG_MOTION_THR: motion_thr = cfg.data[14:0];
					tht_pkg::REG_COLOR_THR:  color_thr = cfg.data[14:0];
					tht_pkg::REG_REACT_PEN:  react_pen = cfg.data;
					tht_pkg::REG_DECAY_RATE: decay = cfg.data;
					tht_pkg::REG_REC_FLOOR:  rec_floor = cfg.data;
					tht_pkg::REG_MIN_WEIGHT: w_min = cfg.data;
					tht_pkg::REG_MAX_WEIGHT: w_max = cfg.data;
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready)
				trust_q.push_back(predict_trust(pix_in.clear_history, pix_in.depth_delta,
					pix_in.motion_length, pix_in.luma_delta, pix_in.reactive_amount,
					pix_in.is_disoccluded, pix_in.prior_trust));
			if (pix_out.valid && pix_out.ready) begin
				if (trust_q.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					e = trust_q.pop_front();
					checked++;
					if (pix_out.combined_trust !== e.combined) begin
						$error("combined_trust: expected %0d, actual %0d", e.combined,
							pix_out.combined_trust);
						fail_count++;
					end
					if (pix_out.history_weight !== e.weight) begin
						$error("history_weight: expected %0d, actual %0d", e.weight,
							pix_out.history_weight);
						fail_count++;
					end
					if (pix_out.rejection !== e.rejection) begin
						$error("rejection: expected %0d, actual %0d", e.rejection,
							pix_out.rejection);
						fail_count++;
					end
					if (pix_out.evidence_trust !== e.evidence) begin
						$error("evidence_trust: expected %0d, actual %0d", e.evidence,
							pix_out.evidence_trust);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ tb/sv/temporal_history_trust_tb.sv @@
// top of the temporal history trust testbench: clock, reset, stimulus and verdict
// depends on tht_pkg, tht_ifs, the block itself and tht_trust_checker
module temporal_history_trust_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_REGS = 8;
	localparam int NUM_PHASES = 7;
	localparam int WORDS_PER_PHASE = 85;
	localparam int DRAIN_CYCLES = 25;        // drain margin beyond the pipeline depth
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit calm;                                // no idling on either side while set
	int unsigned cycles;
	int unsigned fail_count, pending, checked;

	tht_pix_in_if  pix_in_bus();
	tht_pix_out_if pix_out_bus();
	tht_cfg_if     cfg_bus();

	temporal_history_trust i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus),
		.cfg     (cfg_bus)
	);

	tht_trust_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in_bus),
		.pix_out    (pix_out_bus),
		.cfg        (cfg_bus),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly no gap, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// downstream back-pressure
	int stall_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_out_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pix_out_bus.ready <= 1'b0;
		end else begin
			pix_out_bus.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
		end
	end

	// one pixel word; valid stays high into the next word when there is no gap
	task automatic send_pix(bit clr, logic [15:0] dd, logic [15:0] ml, logic [15:0] ld,
			logic [15:0] ra, bit dis, logic [15:0] prior);
		int g;
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.clear_history <= clr;
		pix_in_bus.depth_delta <= dd;
		pix_in_bus.motion_length <= ml;
		pix_in_bus.luma_delta <= ld;
		pix_in_bus.reactive_amount <= ra;
		pix_in_bus.is_disoccluded <= dis;
		pix_in_bus.prior_trust <= prior;
		@(posedge clk);
		while (!pix_in_bus.ready) @(posedge clk);
		g = gap_len();
		if (g > 0) begin
			pix_in_bus.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [tht_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// delta biased toward the small values where the divide path is exercised
	function automatic logic [15:0] rand_delta();
		logic [15:0] m;
		if ($urandom_range(0, 9) < 4) return 16'($urandom);
		m = 16'($urandom_range(0, 4096));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [15:0] rand_q15();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 2048));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic random_pix();
		send_pix($urandom_range(0, 19) == 0, rand_delta(), rand_delta(), rand_delta(),
			rand_q15(), $urandom_range(0, 9) == 0, rand_q15());
	endtask

	// let the pipeline drain before touching the registers
	task automatic wait_idle();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(int phase);
		logic [15:0] v [NUM_REGS];
		case (phase)
			1: v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
				16'hffff};
			2: v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
				16'h0000};
			3: v = '{16'd300, 16'd1500, 16'd2500, 16'd2048, 16'd32768, 16'd2000, 16'd30000,
				16'd5000};
			4: v = '{16'd1, 16'd4096, 16'd8000, 16'd8192, 16'd0, 16'd0, 16'd0, 16'd32768};
			default: begin
				foreach (v[i]) v[i] = $urandom_range(0, 1) ? 16'($urandom)
					: 16'($urandom_range(0, 4096));
			end
		endcase
		write_reg(tht_pkg::REG_DEPTH_THR, v[0]);
		write_reg(tht_pkg::REG_MOTION_THR, v[1]);
		write_reg(tht_pkg::REG_COLOR_THR, v[2]);
		write_reg(tht_pkg::REG_REACT_PEN, v[3]);
		write_reg(tht_pkg::REG_DECAY_RATE, v[4]);
		write_reg(tht_pkg::REG_REC_FLOOR, v[5]);
		write_reg(tht_pkg::REG_MIN_WEIGHT, v[6]);
		write_reg(tht_pkg::REG_MAX_WEIGHT, v[7]);
		// indexes past the register file must be ignored
		write_reg(tht_pkg::CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
			16'($urandom));
	endtask

	initial begin
		pix_in_bus.valid = 1'b0;
		pix_in_bus.clear_history = 1'b0;
		pix_in_bus.depth_delta = '0;
		pix_in_bus.motion_length = '0;
		pix_in_bus.luma_delta = '0;
		pix_in_bus.reactive_amount = '0;
		pix_in_bus.is_disoccluded = 1'b0;
		pix_in_bus.prior_trust = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = tht_pkg::REG_DEPTH_THR;
		cfg_bus.data = '0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the reset register values
		send_pix(1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b1, 16'hffff);  // clear
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h8000);  // full trust
		send_pix(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h8000);  // depth negative
		send_pix(1'b0, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h8000);  // depth max
		send_pix(1'b0, 16'd200, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h8000);   // depth divide
		send_pix(1'b0, 16'd410, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h8000);   // depth at thr
		send_pix(1'b0, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h8000);  // motion -max
		send_pix(1'b0, 16'h0000, -16'sd1000, 16'h0000, 16'h0000, 1'b0, 16'h8000);
		send_pix(1'b0, 16'h0000, 16'd1000, 16'h8000, 16'h0000, 1'b0, 16'h8000);
		send_pix(1'b0, 16'h0000, 16'h0000, -16'sd1600, 16'h0000, 1'b0, 16'h8000);
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 1'b0, 16'h8000);
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, 16'h8000);  // reactive one
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0, 16'h8000);  // above one
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'd5000, 1'b0, 16'h8000);
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000);  // disoccluded
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);  // floor wins
		send_pix(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'hffff);  // prior > one
		send_pix(1'b0, 16'd100, 16'd500, 16'd800, 16'd1000, 1'b0, 16'd20000);
		send_pix(1'b0, 16'd409, 16'd2047, 16'd3276, 16'd0, 1'b0, 16'd100);      // tiny combined

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				// stop offering words so the pipeline can empty
				pix_in_bus.valid <= 1'b0;
				wait_idle();
				set_regs(phase);
			end
			calm = (phase % 3 == 1);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (n == WORDS_PER_PHASE / 2) calm = !calm;
				random_pix();
			end
		end
		pix_in_bus.valid <= 1'b0;
		wait_idle();

		$display("run covered %0d result words over %0d register settings", checked,
			NUM_PHASES);
		$display("checks failed: %0d", fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tht_pkg.sv
hdl/tht_ifs.sv
hdl/tht_div.sv
hdl/temporal_history_trust.sv
tb/sv/tht_trust_checker.sv
tb/sv/temporal_history_trust_tb.sv
